// ===== design/lidbs_pkg.sv =====
package lidbs_pkg;

    // blink sequence constants
    localparam logic [4:0] PREAMBLE_TOGGLES = 5'd4;
    localparam logic [4:0] BITS_PER_CHANNEL = 5'd16;

    // configuration register defaults
    localparam logic [15:0] BIT_TICKS_RESET      = 16'd500;
    localparam logic [15:0] OVERHEAD_TICKS_RESET = 16'd100;

    // configuration register indexes
    localparam logic CFG_BIT_TICKS      = 1'b0;
    localparam logic CFG_OVERHEAD_TICKS = 1'b1;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // led level pairs, bit 0 red, bit 1 green
    localparam logic [1:0] LEDS_OFF = 2'b00;
    localparam logic [1:0] LEDS_ON  = 2'b11;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEADIN = 3'd1,
        PH_PRE1   = 3'd2,
        PH_DATA   = 3'd3,
        PH_PRE2   = 3'd4
    } phase_t;

    typedef struct packed {
        logic finished;
        logic busy_res;
        logic green_led;
        logic red_led;
    } lidbs_result_t;

    // red shows bit i of the low half, green bit i of the high half
    function automatic logic [1:0] data_levels(input logic [31:0] id, input logic [3:0] idx);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = id[15:0];
        hi = id[31:16];
        return {hi[idx], lo[idx]};
    endfunction

endpackage

// ===== design/lidbs_seq.sv =====
module lidbs_seq
    import lidbs_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  logic          req_type,
    input  logic [31:0]   id_value,
    input  logic [15:0]   bit_ticks,
    input  logic [15:0]   overhead_ticks,
    output lidbs_result_t result
);

    phase_t      phase_reg, phase_next;
    logic [19:0] tick_count_reg, tick_count_next;
    logic [4:0]  bit_index_reg, bit_index_next;
    logic [31:0] id_store_reg, id_store_next;
    logic [1:0]  led_reg, led_next;
    logic        fin_next;

    logic [16:0] pre_sum;
    logic [16:0] pre_len;
    logic [16:0] data_len;
    logic [16:0] period_len;
    logic [19:0] tick_inc;
    logic [4:0]  bit_inc;
    logic        period_end;

    // period lengths, a zero length is held for one tick
    assign pre_sum  = {1'b0, bit_ticks} + {1'b0, overhead_ticks};
    assign pre_len  = (pre_sum == 17'd0) ? 17'd1 : pre_sum;
    assign data_len = (bit_ticks == 16'd0) ? 17'd1 : {1'b0, bit_ticks};

    assign period_len = (phase_reg == PH_DATA) ? data_len : pre_len;
    assign tick_inc   = tick_count_reg + 20'd1;
    assign bit_inc    = bit_index_reg + 5'd1;
    assign period_end = (tick_inc >= {3'b000, period_len});

    // next state
    always_comb begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        id_store_next   = id_store_reg;
        led_next        = led_reg;
        fin_next        = 1'b0;
        if (req_type == REQ_START) begin
            if (phase_reg == PH_IDLE) begin
                id_store_next   = id_value;
                phase_next      = PH_LEADIN;
                tick_count_next = 20'd0;
                bit_index_next  = 5'd0;
                led_next        = LEDS_OFF;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    led_next = LEDS_OFF;
                end
                PH_LEADIN: begin
                    tick_count_next = tick_inc;
                    if (period_end) begin
                        tick_count_next = 20'd0;
                        bit_index_next  = bit_inc;
                        if (bit_inc >= PREAMBLE_TOGGLES) begin
                            phase_next     = PH_PRE1;
                            bit_index_next = 5'd0;
                            led_next       = LEDS_ON;
                        end
                    end
                end
                PH_PRE1, PH_PRE2: begin
                    tick_count_next = tick_inc;
                    if (period_end) begin
                        tick_count_next = 20'd0;
                        bit_index_next  = bit_inc;
                        led_next        = led_reg ^ LEDS_ON;
                        if (bit_inc >= PREAMBLE_TOGGLES) begin
                            bit_index_next = 5'd0;
                            if (phase_reg == PH_PRE1) begin
                                phase_next = PH_DATA;
                                led_next   = data_levels(id_store_reg, 4'd0);
                            end else begin
                                phase_next = PH_IDLE;
                                led_next   = LEDS_OFF;
                                fin_next   = 1'b1;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    tick_count_next = tick_inc;
                    if (period_end) begin
                        tick_count_next = 20'd0;
                        bit_index_next  = bit_inc;
                        if (bit_inc >= BITS_PER_CHANNEL) begin
                            phase_next     = PH_PRE2;
                            bit_index_next = 5'd0;
                            led_next       = LEDS_ON;
                        end else begin
                            led_next = data_levels(id_store_reg, bit_inc[3:0]);
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    led_next   = LEDS_OFF;
                end
            endcase
        end
    end

    // result fields follow the state after this item
    always_comb begin
        result.red_led   = led_next[0];
        result.green_led = led_next[1];
        result.busy_res  = (phase_next != PH_IDLE);
        result.finished  = fin_next;
    end

    // state registers advance once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= 20'd0;
            bit_index_reg  <= 5'd0;
            id_store_reg   <= 32'd0;
            led_reg        <= LEDS_OFF;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            id_store_reg   <= id_store_next;
            led_reg        <= led_next;
        end
    end

endmodule

// ===== design/led_id_blink_serializer_top.sv =====
// Blinks a 32-bit identifier on a red and a green LED. A start transfer
// (tuser 1) captures the identifier from tdata; tick transfers (tuser 0)
// then step a lead-in with both LEDs off, a toggling preamble, sixteen data
// bits least significant first (red the low half, green the high half) and
// a closing preamble. Every input transfer yields exactly one result giving
// the LED levels and busy flag after it; tlast marks the result that ends
// the closing preamble. Starts while busy are ignored. The block takes one
// transfer per cycle unless the output side's tready holds it: an input
// register feeds the sequencer, whose result goes to an output register,
// and only that tready sets the throughput. Write bit_ticks and
// overhead_ticks only while no transfer is in flight; a new value applies
// from the next tick, also in the middle of a sequence.
module led_id_blink_serializer_top
    import lidbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // id_value
    input  logic        s_axis_tuser,   // req_type
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // red_led, green_led, busy_res, zero pad
    output logic        m_axis_tlast    // finished
);

    logic [15:0]   bit_ticks_reg;
    logic [15:0]   overhead_ticks_reg;
    logic          in_valid_reg;
    logic          in_type_reg;
    logic [31:0]   in_id_reg;
    logic          out_valid_reg;
    lidbs_result_t out_reg;
    lidbs_result_t seq_result;
    logic          advance;
    logic          step_en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg      <= BIT_TICKS_RESET;
            overhead_ticks_reg <= OVERHEAD_TICKS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_BIT_TICKS:      bit_ticks_reg      <= cfg_wdata;
                CFG_OVERHEAD_TICKS: overhead_ticks_reg <= cfg_wdata;
                default:            bit_ticks_reg      <= bit_ticks_reg;
            endcase
        end
    end

    // pipeline moves when the output register is free or being taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_type_reg <= s_axis_tuser;
            in_id_reg   <= s_axis_tdata;
        end
    end

    lidbs_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (step_en),
        .req_type       (in_type_reg),
        .id_value       (in_id_reg),
        .bit_ticks      (bit_ticks_reg),
        .overhead_ticks (overhead_ticks_reg),
        .result         (seq_result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_reg <= seq_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.busy_res, out_reg.green_led, out_reg.red_led};
    assign m_axis_tlast  = out_reg.finished;

endmodule
